### src/mck_pkg.sv
`timescale 1ns / 1ps

package mck_pkg;

	localparam int TIME_WIDTH = 20;

	localparam logic [TIME_WIDTH-1:0] DOT_TIME_RST  = TIME_WIDTH'(30000);
	localparam logic [TIME_WIDTH-1:0] DASH_TIME_RST = TIME_WIDTH'(90000);
	localparam logic [TIME_WIDTH-1:0] GAP_TIME_RST  = TIME_WIDTH'(30000);

	// configuration register indexes
	localparam logic [1:0] REG_DOT_TIME  = 2'd0;
	localparam logic [1:0] REG_DASH_TIME = 2'd1;
	localparam logic [1:0] REG_GAP_TIME  = 2'd2;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_message;
	} mck_in_t;

	typedef struct packed {
		logic                  led_on;
		logic [TIME_WIDTH-1:0] duration;
		logic                  last;
	} mck_out_t;

	typedef enum logic [1:0] {
		SEG_DOT,
		SEG_DASH,
		SEG_GAP
	} mck_seg_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     emit;
		mck_seg_t kind;
		logic     last;
		logic     shift;
		logic     clr_cnt;
		logic     inc_cnt;
	} mck_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_has_marks;
		logic out_free;
		logic cur_dash;
		logic rem_is_one;
		logic eom;
		logic cnt_is_two;
	} mck_sts_t;

	// pattern: bit 0 is the first mark, 1 means dash
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] pat;
	} mck_code_t;

	function automatic mck_code_t mck_lookup(input logic [7:0] symbol);
		mck_code_t c;
		c = '{len: 3'd0, pat: 5'b00000};
		unique case (symbol)
			8'h41: c = '{len: 3'd2, pat: 5'b00010}; // A
			8'h42: c = '{len: 3'd4, pat: 5'b00001}; // B
			8'h43: c = '{len: 3'd4, pat: 5'b00101}; // C
			8'h44: c = '{len: 3'd3, pat: 5'b00001}; // D
			8'h45: c = '{len: 3'd1, pat: 5'b00000}; // E
			8'h46: c = '{len: 3'd4, pat: 5'b00100}; // F
			8'h47: c = '{len: 3'd3, pat: 5'b00011}; // G
			8'h48: c = '{len: 3'd4, pat: 5'b00000}; // H
			8'h49: c = '{len: 3'd2, pat: 5'b00000}; // I
			8'h4A: c = '{len: 3'd4, pat: 5'b01110}; // J
			8'h4B: c = '{len: 3'd3, pat: 5'b00101}; // K
			8'h4C: c = '{len: 3'd4, pat: 5'b00010}; // L
			8'h4D: c = '{len: 3'd2, pat: 5'b00011}; // M
			8'h4E: c = '{len: 3'd2, pat: 5'b00001}; // N
			8'h4F: c = '{len: 3'd3, pat: 5'b00111}; // O
			8'h50: c = '{len: 3'd4, pat: 5'b00110}; // P
			8'h51: c = '{len: 3'd4, pat: 5'b01011}; // Q
			8'h52: c = '{len: 3'd3, pat: 5'b00010}; // R
			8'h53: c = '{len: 3'd3, pat: 5'b00000}; // S
			8'h54: c = '{len: 3'd1, pat: 5'b00001}; // T
			8'h55: c = '{len: 3'd3, pat: 5'b00100}; // U
			8'h56: c = '{len: 3'd4, pat: 5'b01000}; // V
			8'h57: c = '{len: 3'd3, pat: 5'b00110}; // W
			8'h58: c = '{len: 3'd4, pat: 5'b01001}; // X
			8'h59: c = '{len: 3'd4, pat: 5'b01101}; // Y
			8'h5A: c = '{len: 3'd4, pat: 5'b00011}; // Z
			8'h30: c = '{len: 3'd5, pat: 5'b11111}; // 0
			8'h31: c = '{len: 3'd5, pat: 5'b11110}; // 1
			8'h32: c = '{len: 3'd5, pat: 5'b11100}; // 2
			8'h33: c = '{len: 3'd5, pat: 5'b11000}; // 3
			8'h34: c = '{len: 3'd5, pat: 5'b10000}; // 4
			8'h35: c = '{len: 3'd5, pat: 5'b00000}; // 5
			8'h36: c = '{len: 3'd5, pat: 5'b00001}; // 6
			8'h37: c = '{len: 3'd5, pat: 5'b00011}; // 7
			8'h38: c = '{len: 3'd5, pat: 5'b00111}; // 8
			8'h39: c = '{len: 3'd5, pat: 5'b01111}; // 9
			default: c = '{len: 3'd0, pat: 5'b00000};
		endcase
		return c;
	endfunction

endpackage

### src/mck_dp.sv
`timescale 1ns / 1ps

module mck_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mck_pkg::mck_in_t              in_data,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [mck_pkg::TIME_WIDTH-1:0] cfg_data,
	input  mck_pkg::mck_cmd_t             cmd,
	output mck_pkg::mck_sts_t             sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mck_pkg::mck_out_t             out_data
);
	import mck_pkg::*;

	logic [TIME_WIDTH-1:0] dot_time_q, dash_time_q, gap_time_q;
	logic [4:0]            pat_q;
	logic [2:0]            rem_q;
	logic                  eom_q;
	logic [1:0]            cnt_q;
	logic                  out_valid_q;
	mck_out_t              out_q;
	mck_code_t             code;

	assign code = mck_lookup(in_data.symbol);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_time_q  <= DOT_TIME_RST;
			dash_time_q <= DASH_TIME_RST;
			gap_time_q  <= GAP_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DOT_TIME:  dot_time_q  <= cfg_data;
				REG_DASH_TIME: dash_time_q <= cfg_data;
				REG_GAP_TIME:  gap_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			rem_q <= '0;
			eom_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				pat_q <= code.pat;
				rem_q <= code.len;
				eom_q <= in_data.end_of_message;
			end else if (cmd.shift) begin
				pat_q <= {1'b0, pat_q[4:1]};
				rem_q <= rem_q - 3'd1;
			end
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.inc_cnt) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.last <= cmd.last;
			unique case (cmd.kind)
				SEG_DOT: begin
					out_q.led_on   <= 1'b1;
					out_q.duration <= dot_time_q;
				end
				SEG_DASH: begin
					out_q.led_on   <= 1'b1;
					out_q.duration <= dash_time_q;
				end
				default: begin
					out_q.led_on   <= 1'b0;
					out_q.duration <= gap_time_q;
				end
			endcase
		end
	end

	assign sts.in_has_marks = (code.len != 3'd0);
	assign sts.out_free     = !out_valid_q || out_ready;
	assign sts.cur_dash     = pat_q[0];
	assign sts.rem_is_one   = (rem_q == 3'd1);
	assign sts.eom          = eom_q;
	assign sts.cnt_is_two   = (cnt_q == 2'd2);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/mck_ctrl.sv
`timescale 1ns / 1ps

module mck_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mck_pkg::mck_sts_t sts,
	output mck_pkg::mck_cmd_t cmd
);
	import mck_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_IGAP,
		ST_CGAP,
		ST_EGAP
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '{load: 1'b0, emit: 1'b0, kind: SEG_GAP, last: 1'b0,
		            shift: 1'b0, clr_cnt: 1'b0, inc_cnt: 1'b0};
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.in_has_marks ? ST_MARK : ST_CGAP;
				end
			end
			ST_MARK: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = sts.cur_dash ? SEG_DASH : SEG_DOT;
					cmd.shift = 1'b1;
					state_d   = sts.rem_is_one ? ST_CGAP : ST_IGAP;
				end
			end
			ST_IGAP: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_MARK;
				end
			end
			ST_CGAP: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.last    = !sts.eom;
					cmd.clr_cnt = 1'b1;
					state_d     = sts.eom ? ST_EGAP : ST_IDLE;
				end
			end
			ST_EGAP: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.last    = sts.cnt_is_two;
					cmd.inc_cnt = 1'b1;
					state_d     = sts.cnt_is_two ? ST_IDLE : ST_EGAP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/morse_code_keyer_unit.sv
`timescale 1ns / 1ps
// Morse keyer: one ASCII character per transaction in, timed LED segments out.
// The character is first loaded into the pattern register; its first segment then goes to the output register.
// Throughput: one segment per cycle within a character while out_ready holds;
//   the next character is accepted only after the sequencer returns to idle.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, timing
//   registers back to dot 30000, dash 90000, gap 30000.

module morse_code_keyer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mck_pkg::mck_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mck_pkg::mck_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [mck_pkg::TIME_WIDTH-1:0] cfg_data
);
	import mck_pkg::*;

	mck_cmd_t cmd;
	mck_sts_t sts;

	// Sequencer: walk marks, inter-mark gaps, the character-end gap and, on
	// end of message, three trailing gaps. Out of idle it advances only when
	// the output register is free or being drained this cycle.
	mck_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: timing registers, code lookup, pattern shift register,
	// mark and gap counters, and the output register that holds a segment
	// until the downstream transaction completes.
	mck_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### bench/keyer_board_pkg.sv
`timescale 1ns / 1ps

package keyer_board_pkg;

	import mck_pkg::*;

	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_Z    = 8'h5A;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int MAX_SEGMENTS = 13;
	localparam int SHOW_LIMIT   = 10;

	class keyer_board;
		mck_out_t              pending_segments[$];
		logic [TIME_WIDTH-1:0] dot_len;
		logic [TIME_WIDTH-1:0] dash_len;
		logic [TIME_WIDTH-1:0] gap_len;
		int unsigned           faults;
		int unsigned           shown;
		string                 code_book [36];

		function new();
			// letters A-Z, then digits 0-9
			code_book = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
				".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
				"...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
				"-----", ".----", "..---", "...--", "....-", ".....", "-....",
				"--...", "---..", "----."};
			dot_len  = DOT_TIME_RST;
			dash_len = DASH_TIME_RST;
			gap_len  = GAP_TIME_RST;
			faults   = 0;
			shown    = 0;
		endfunction

		function void set_timing(logic [1:0] index, logic [TIME_WIDTH-1:0] value);
			case (index)
				REG_DOT_TIME:  dot_len  = value;
				REG_DASH_TIME: dash_len = value;
				REG_GAP_TIME:  gap_len  = value;
				default: ;
			endcase
		endfunction

		// expand one character into its keyed segments
		function void add_character(mck_in_t item);
			string                 marks;
			logic                  on_list [MAX_SEGMENTS];
			logic [TIME_WIDTH-1:0] dur_list [MAX_SEGMENTS];
			int                    n;
			mck_out_t              seg;
			marks = "";
			n = 0;
			if (item.symbol >= CH_A && item.symbol <= CH_Z)
				marks = code_book[int'(item.symbol - CH_A)];
			else if (item.symbol >= CH_0 && item.symbol <= CH_9)
				marks = code_book[26 + int'(item.symbol - CH_0)];
			for (int i = 0; i < marks.len(); i++) begin
				if (i > 0) begin
					on_list[n]  = 1'b0;
					dur_list[n] = gap_len;
					n++;
				end
				on_list[n]  = 1'b1;
				dur_list[n] = (marks[i] == "-") ? dash_len : dot_len;
				n++;
			end
			for (int g = 0; g < (item.end_of_message ? 4 : 1); g++) begin
				on_list[n]  = 1'b0;
				dur_list[n] = gap_len;
				n++;
			end
			for (int i = 0; i < n; i++) begin
				seg.led_on   = on_list[i];
				seg.duration = dur_list[i];
				seg.last     = (i == n - 1);
				pending_segments.push_back(seg);
			end
		endfunction

		function void check_segment(mck_out_t got);
			mck_out_t want;
			if (pending_segments.size() == 0) begin
				faults++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("unexpected segment: on=%0d dur=%0d last=%0d",
						got.led_on, got.duration, got.last);
				end
				return;
			end
			want = pending_segments.pop_front();
			if (got.led_on !== want.led_on || got.duration !== want.duration ||
					got.last !== want.last) begin
				faults++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("segment mismatch: expected on=%0d dur=%0d last=%0d, got on=%0d dur=%0d last=%0d",
						want.led_on, want.duration, want.last,
						got.led_on, got.duration, got.last);
				end
			end
		endfunction
	endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import mck_pkg::*;
	import keyer_board_pkg::*;

	localparam int          HALF_PERIOD  = 4;
	localparam int          RESET_CYCLES = 12;
	localparam int          CHOKE_CYCLES = 400;
	localparam int          SETTLE       = 16;
	localparam int unsigned LIMIT        = 400000;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	// probe characters: alphabet and digit ends, single marks, lower case,
	// codes just outside the recognized ranges, all-zero and all-one bytes
	localparam logic [7:0] PROBE_SYMS [20] = '{
		8'h41, 8'h5A, 8'h30, 8'h39, 8'h35, 8'h45, 8'h54, 8'h51, 8'h59, 8'h61,
		8'h00, 8'hFF, 8'h40, 8'h5B, 8'h2F, 8'h3A, 8'h7A, 8'h30, 8'h45, 8'hFF};
	localparam logic [19:0] PROBE_EOM = 20'b1101_0000_0010_0000_0100;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	mck_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	mck_out_t out_data;
	logic     cfg_we;
	logic [1:0] cfg_index;
	logic [TIME_WIDTH-1:0] cfg_data;

	keyer_board  board;
	int unsigned cycle_count;
	bit          lazy_tx;
	bit          lazy_rx;
	bit          choke_req;

	morse_code_keyer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// hard stop for a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one character. Hold valid across back-to-back transactions so it
	// never drops and rises in the same step; leave on a falling edge.
	task automatic send_char(input logic [7:0] sym, input logic eom);
		int unsigned idle;
		idle = lazy_tx ? $urandom_range(0, 15) : 0;
		if (idle != 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{symbol: sym, end_of_message: eom};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.add_character(in_data);
		@(negedge clk);
	endtask

	// Write one timing register; the block is idle whenever this is called.
	task automatic write_timing(input logic [1:0] index, input logic [TIME_WIDTH-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		board.set_timing(index, value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected segment, then let the sequencer settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_segments.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Mostly recognized characters so the mark sequencer is exercised; the rest
	// are arbitrary bytes. End of message on about a quarter.
	task automatic send_random(input int count);
		logic [7:0] sym;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: sym = CH_A + 8'($urandom_range(0, 25));
				4, 5, 6:    sym = CH_0 + 8'($urandom_range(0, 9));
				default:    sym = 8'($urandom_range(0, 255));
			endcase
			send_char(sym, $urandom_range(0, 3) == 0);
		end
	endtask

	function automatic logic [TIME_WIDTH-1:0] random_len();
		return TIME_WIDTH'($urandom_range(1, int'(TIME_MAX)));
	endfunction

	// Receiver: when lazy_rx is set, stall a random count before each segment, or hold off for a
	// long stretch when asked so the block backs up into its input.
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (choke_req) begin
				out_ready <= 1'b0;
				for (int n = 0; n < CHOKE_CYCLES; n++)
					@(negedge clk);
				choke_req = 1'b0;
			end
			stall = lazy_rx ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			board.check_segment(out_data);
			@(negedge clk);
		end
	end

	initial begin
		board       = new();
		cycle_count = 0;
		lazy_tx     = 1'b1;
		lazy_rx     = 1'b1;
		choke_req   = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset timing, directed characters
		for (int i = 0; i < 20; i++)
			send_char(PROBE_SYMS[i], PROBE_EOM[19 - i]);
		drain();

		// timing of one everywhere, receiver never stalls
		write_timing(REG_DOT_TIME, TIME_WIDTH'(1));
		write_timing(REG_DASH_TIME, TIME_WIDTH'(1));
		write_timing(REG_GAP_TIME, TIME_WIDTH'(1));
		lazy_rx = 1'b0;
		send_random(30);
		drain();

		// longest timing; a write to the unused index must change nothing
		write_timing(REG_DOT_TIME, TIME_MAX);
		write_timing(REG_DASH_TIME, TIME_MAX);
		write_timing(REG_GAP_TIME, TIME_MAX);
		write_timing(REG_NONE, random_len());
		lazy_rx = 1'b1;
		send_random(30);
		drain();

		// zero dot length is copied through; no idling on either side
		write_timing(REG_DOT_TIME, '0);
		write_timing(REG_DASH_TIME, random_len());
		write_timing(REG_GAP_TIME, random_len());
		lazy_tx = 1'b0;
		lazy_rx = 1'b0;
		send_random(30);
		drain();

		// zero dash and gap; receiver chokes while the sender keeps pushing
		write_timing(REG_DOT_TIME, random_len());
		write_timing(REG_DASH_TIME, '0);
		write_timing(REG_GAP_TIME, '0);
		choke_req = 1'b1;
		send_random(30);
		drain();

		// random lengths, both sides idle at random
		write_timing(REG_DOT_TIME, random_len());
		write_timing(REG_DASH_TIME, random_len());
		write_timing(REG_GAP_TIME, random_len());
		write_timing(REG_NONE, '0);
		lazy_tx = 1'b1;
		lazy_rx = 1'b1;
		send_random(30);
		drain();

		if (board.faults == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
